### rtl/core/byte_vm_instruction_executor_defines.svh
// Assertion macros shared by the byte machine executor RTL.
`ifndef BYTE_VM_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define BYTE_VM_INSTRUCTION_EXECUTOR_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BVM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bvm assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define BVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bvm assertion failed");

`endif

### rtl/core/bvm_pkg.sv
// Package with types, codes and helpers of the byte machine executor.
`default_nettype none
package bvm_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int STK_AW      = $clog2(STACK_DEPTH);
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);

  localparam logic [11:0] PC_RESET   = 12'h200;
  localparam logic [11:0] FONT_RESET = 12'd80;

  localparam logic [2:0] KIND_DONE  = 3'd0;
  localparam logic [2:0] KIND_MEMW  = 3'd1;
  localparam logic [2:0] KIND_DELAY = 3'd2;
  localparam logic [2:0] KIND_SOUND = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_OP  = 3'd1;
  localparam logic [2:0] ST_BAD_JMP = 3'd2;
  localparam logic [2:0] ST_BAD_KEY = 3'd3;
  localparam logic [2:0] ST_OVER    = 3'd4;
  localparam logic [2:0] ST_UNDER   = 3'd5;
  localparam logic [2:0] ST_KEYWAIT = 3'd6;
  localparam logic [2:0] ST_UNSUP   = 3'd7;

  localparam logic [15:0] OP_CLS = 16'h00E0;
  localparam logic [15:0] OP_RET = 16'h00EE;
  localparam logic [7:0]  SUB_SKP    = 8'h9E;
  localparam logic [7:0]  SUB_SKNP   = 8'hA1;
  localparam logic [7:0]  SUB_GETDT  = 8'h07;
  localparam logic [7:0]  SUB_GETKEY = 8'h0A;
  localparam logic [7:0]  SUB_SETDT  = 8'h15;
  localparam logic [7:0]  SUB_SETST  = 8'h18;
  localparam logic [7:0]  SUB_ADDI   = 8'h1E;
  localparam logic [7:0]  SUB_FONT   = 8'h29;
  localparam logic [7:0]  SUB_BCD    = 8'h33;
  localparam logic [7:0]  SUB_STORE  = 8'h55;
  localparam logic [7:0]  SUB_LOAD   = 8'h65;

  localparam logic [3:0] GRP_SYS  = 4'h0;
  localparam logic [3:0] GRP_JP   = 4'h1;
  localparam logic [3:0] GRP_CALL = 4'h2;
  localparam logic [3:0] GRP_SE   = 4'h3;
  localparam logic [3:0] GRP_SNE  = 4'h4;
  localparam logic [3:0] GRP_SER  = 4'h5;
  localparam logic [3:0] GRP_LD   = 4'h6;
  localparam logic [3:0] GRP_ADD  = 4'h7;
  localparam logic [3:0] GRP_ALU  = 4'h8;
  localparam logic [3:0] GRP_SNER = 4'h9;
  localparam logic [3:0] GRP_LDI  = 4'hA;
  localparam logic [3:0] GRP_JPV  = 4'hB;
  localparam logic [3:0] GRP_RND  = 4'hC;
  localparam logic [3:0] GRP_DRW  = 4'hD;
  localparam logic [3:0] GRP_KEY  = 4'hE;

  localparam logic [3:0] ALU_MOV = 4'h0;
  localparam logic [3:0] ALU_OR  = 4'h1;
  localparam logic [3:0] ALU_AND = 4'h2;
  localparam logic [3:0] ALU_XOR = 4'h3;
  localparam logic [3:0] ALU_ADD = 4'h4;
  localparam logic [3:0] ALU_SUB = 4'h5;
  localparam logic [3:0] ALU_SHR = 4'h6;
  localparam logic [3:0] ALU_SUBN = 4'h7;
  localparam logic [3:0] ALU_SHL = 4'hE;

  typedef enum logic [2:0] {
    U_ADD, U_SUB, U_OR, U_AND, U_XOR, U_SHR, U_SHL
  } unit_op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EX, S_FLAG, S_FONT, S_OUT, S_WRD, S_WR
  } state_t;

  // One decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 ones.
  function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
    logic [7:0]  h;
    logic [7:0]  r;
    logic [15:0] prod;
    logic [7:0]  t;
    logic [7:0]  o;
    h = (v >= 8'd200) ? 8'd2 : ((v >= 8'd100) ? 8'd1 : 8'd0);
    r = (v >= 8'd200) ? (v - 8'd200) : ((v >= 8'd100) ? (v - 8'd100) : v);
    prod = {8'd0, r} * 16'd205;
    t = {5'd0, prod[13:11]} + {7'd0, prod[14]} * 8'd8;
    o = r - t * 8'd10;
    case (sel)
      2'd0:    return h;
      2'd1:    return t;
      default: return o;
    endcase
  endfunction

endpackage
`default_nettype wire

### rtl/core/bvm_ifs.sv
// Handshake interfaces for the instruction, result and configuration channels.
`default_nettype none
interface bvm_cmd_if;
  logic        valid;
  logic        ready;
  logic [15:0] opcode;
  logic [15:0] key_down_mask;
  logic        key_event_valid;
  logic [3:0]  key_event_index;
  logic [7:0]  random_byte;
  logic [7:0]  delay_timer_now;
  modport source (output valid, opcode, key_down_mask, key_event_valid, key_event_index,
                  random_byte, delay_timer_now, input ready);
  modport sink (input valid, opcode, key_down_mask, key_event_valid, key_event_index,
                random_byte, delay_timer_now, output ready);
endinterface

interface bvm_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] mem_address;
  logic [7:0]  data;
  logic [11:0] next_pc;
  logic [2:0]  status;
  logic        last;
  modport source (output valid, kind, mem_address, data, next_pc, status, last,
                  input ready);
  modport sink (input valid, kind, mem_address, data, next_pc, status, last,
                output ready);
endinterface

interface bvm_cfg_if;
  logic        valid;
  logic        ready;
  logic [11:0] font_base;
  modport source (output valid, font_base, input ready);
  modport sink (input valid, font_base, output ready);
endinterface
`default_nettype wire

### rtl/core/byte_vm_instruction_executor.sv
// Top level of the byte machine instruction executor.
//
// The block executes one 16-bit instruction per accepted item and returns one or
// more result items for it. It takes one item at a time: cmd.ready is high only
// while the sequencer is idle. A typical instruction goes from acceptance to its
// result entering the output register through the accept, register read,
// execute and output states; flagged ALU operations pass through S_FLAG and the
// font lookup through S_FONT, because the register file has a single write port
// and the font address needs two passes through the shared adder. A BCD store
// and a store of V0..Vx repeat S_WRD and S_WR per memory write, which reads one
// register and then waits for the output register. An error leaves all state
// unchanged and gives a single done item carrying the status and the unchanged
// program counter. Configuration writes to font_base are always accepted and
// should only be issued while the block is idle.
`default_nettype none
`include "byte_vm_instruction_executor_defines.svh"
module byte_vm_instruction_executor
  import bvm_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bvm_cmd_if.sink   cmd,
  bvm_res_if.source res,
  bvm_cfg_if.sink   cfg
);
  state_t state, state_next;

  // Latched item.
  logic [15:0] op_q;
  logic [15:0] keys_q;
  logic        kv_q;
  logic [3:0]  ki_q;
  logic [7:0]  rnd_q;
  logic [7:0]  dt_q;

  // Architectural state.
  logic [11:0] pc;
  logic [15:0] index_q;
  logic [SP_W-1:0] sp;
  logic [11:0] font_base_q;
  logic [11:0] stk_mem [STACK_DEPTH];
  logic [11:0] stk_rdata;

  // Sequencer working registers.
  logic [2:0]  status_q;
  logic [2:0]  kind_q;
  logic [7:0]  data_q;
  logic [15:0] tmp_q;
  logic        flag_q;
  logic [7:0]  vx_q;
  logic [3:0]  cnt;
  logic [3:0]  lim;
  logic        bcd_q;

  // Output register.
  logic        res_valid_q;
  logic [2:0]  res_kind_q;
  logic [15:0] res_addr_q;
  logic [7:0]  res_data_q;
  logic [11:0] res_pc_q;
  logic [2:0]  res_status_q;
  logic        res_last_q;
  logic        out_free;

  // Decoded fields.
  logic [3:0]  fx, fy, fn;
  logic [7:0]  nn;
  logic [11:0] nnn;
  logic [7:0]  vx, vy;
  logic [11:0] pc_adv, pc_skip;
  logic [SP_W-1:0] sp_m1;
  logic [STK_AW-1:0] stk_raddr;

  // Shared unit.
  unit_op_t    u_op;
  logic [15:0] u_a, u_b, u_y;
  logic        u_flag;

  // Register file ports.
  logic       rf_we;
  logic [3:0] rf_waddr;
  logic [7:0] rf_wdata;
  logic [3:0] rf_raddr_a;

  // Execute decisions.
  logic [2:0]  ex_status;
  logic [11:0] ex_pc;
  logic        ex_rwe;
  logic [7:0]  ex_rdata;
  logic        ex_flag;
  logic        ex_idx_we;
  logic [15:0] ex_idx;
  logic        ex_push;
  logic        ex_pop;
  logic [2:0]  ex_kind;
  logic [7:0]  ex_data;
  state_t      ex_next;
  logic [3:0]  ex_lim;
  logic        ex_bcd;
  logic        ex_ok;
  logic        wr_last;

  assign fx  = op_q[11:8];
  assign fy  = op_q[7:4];
  assign fn  = op_q[3:0];
  assign nn  = op_q[7:0];
  assign nnn = op_q[11:0];
  assign pc_adv  = pc + 12'd2;
  assign pc_skip = pc + 12'd4;
  assign sp_m1 = sp - {{(SP_W-1){1'b0}}, 1'b1};
  assign stk_raddr = sp_m1[STK_AW-1:0];

  assign cmd.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign out_free  = !res_valid_q || res.ready;
  assign wr_last   = (cnt == lim);

  bvm_unit u_unit (
    .op   (u_op),
    .a    (u_a),
    .b    (u_b),
    .y    (u_y),
    .flag (u_flag)
  );

  // The jump with offset reads V0 on port A; stores walk port A over V0..Vx.
  always_comb begin
    if (state == S_WRD || state == S_WR) begin
      rf_raddr_a = cnt;
    end else if (op_q[15:12] == GRP_JPV) begin
      rf_raddr_a = 4'd0;
    end else begin
      rf_raddr_a = fx;
    end
  end

  bvm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .we      (rf_we),
    .waddr   (rf_waddr),
    .wdata   (rf_wdata),
    .raddr_a (rf_raddr_a),
    .raddr_b (fy),
    .rdata_a (vx),
    .rdata_b (vy)
  );

  // Execute: decide status, new program counter and state updates for one item.
  always_comb begin
    ex_status = ST_OK;
    ex_pc     = pc_adv;
    ex_rwe    = 1'b0;
    ex_rdata  = 8'd0;
    ex_flag   = 1'b0;
    ex_idx_we = 1'b0;
    ex_idx    = u_y;
    ex_push   = 1'b0;
    ex_pop    = 1'b0;
    ex_kind   = KIND_DONE;
    ex_data   = 8'd0;
    ex_next   = S_OUT;
    ex_lim    = 4'd0;
    ex_bcd    = 1'b0;
    u_op      = U_ADD;
    u_a       = {8'd0, vx};
    u_b       = {8'd0, vy};
    case (op_q[15:12])
      GRP_SYS: begin
        if (op_q == OP_CLS) begin
          ex_kind = KIND_CLEAR;
        end else if (op_q == OP_RET) begin
          if (sp == '0) ex_status = ST_UNDER;
          else begin ex_pop = 1'b1; ex_pc = stk_rdata; end
        end else begin
          ex_status = ST_BAD_OP;
        end
      end
      GRP_JP: begin
        if (nnn == 12'd0 || nnn[0]) ex_status = ST_BAD_JMP;
        else ex_pc = nnn;
      end
      GRP_CALL: begin
        if (nnn == 12'd0) ex_status = ST_BAD_OP;
        else if (sp >= SP_W'(STACK_DEPTH)) ex_status = ST_OVER;
        else begin ex_push = 1'b1; ex_pc = nnn; end
      end
      GRP_SE:  if (vx == nn) ex_pc = pc_skip;
      GRP_SNE: if (vx != nn) ex_pc = pc_skip;
      GRP_SER: begin
        if (fn != 4'd0) ex_status = ST_BAD_OP;
        else if (vx == vy) ex_pc = pc_skip;
      end
      GRP_SNER: begin
        if (fn != 4'd0) ex_status = ST_BAD_OP;
        else if (vx != vy) ex_pc = pc_skip;
      end
      GRP_LD: begin ex_rwe = 1'b1; ex_rdata = nn; end
      GRP_ADD: begin
        u_b = {8'd0, nn};
        ex_rwe = 1'b1;
        ex_rdata = u_y[7:0];
      end
      GRP_ALU: begin
        ex_rwe = 1'b1;
        ex_rdata = u_y[7:0];
        case (fn)
          ALU_MOV: ex_rdata = vy;
          ALU_OR:  u_op = U_OR;
          ALU_AND: u_op = U_AND;
          ALU_XOR: u_op = U_XOR;
          ALU_ADD: begin u_op = U_ADD; ex_flag = 1'b1; end
          ALU_SUB: begin u_op = U_SUB; ex_flag = 1'b1; end
          ALU_SHR: begin u_op = U_SHR; ex_flag = 1'b1; end
          ALU_SUBN: begin
            u_op = U_SUB;
            u_a = {8'd0, vy};
            u_b = {8'd0, vx};
            ex_flag = 1'b1;
          end
          ALU_SHL: begin u_op = U_SHL; ex_flag = 1'b1; end
          default: begin ex_status = ST_BAD_OP; ex_rwe = 1'b0; end
        endcase
        if (ex_flag) ex_next = S_FLAG;
      end
      GRP_LDI: begin ex_idx_we = 1'b1; ex_idx = {4'd0, nnn}; end
      GRP_JPV: begin
        // Port A holds V0 here.
        u_a = {4'd0, nnn};
        u_b = {8'd0, vx};
        if (u_y == 16'd0 || u_y > 16'h0FFF || u_y[0]) ex_status = ST_BAD_JMP;
        else ex_pc = u_y[11:0];
      end
      GRP_RND: begin ex_rwe = 1'b1; ex_rdata = rnd_q & nn; end
      GRP_DRW: ex_status = ST_UNSUP;
      GRP_KEY: begin
        if (vx > 8'd15) ex_status = ST_BAD_KEY;
        else if (nn == SUB_SKP) begin
          if (keys_q[vx[3:0]]) ex_pc = pc_skip;
        end else if (nn == SUB_SKNP) begin
          if (!keys_q[vx[3:0]]) ex_pc = pc_skip;
        end else ex_status = ST_BAD_OP;
      end
      default: begin
        case (nn)
          SUB_GETDT: begin ex_rwe = 1'b1; ex_rdata = dt_q; end
          SUB_GETKEY: begin
            if (kv_q) begin ex_rwe = 1'b1; ex_rdata = {4'd0, ki_q}; end
            else ex_status = ST_KEYWAIT;
          end
          SUB_SETDT: begin ex_kind = KIND_DELAY; ex_data = vx; end
          SUB_SETST: begin ex_kind = KIND_SOUND; ex_data = vx; end
          SUB_ADDI: begin
            u_a = index_q;
            u_b = {8'd0, vx};
            ex_idx_we = 1'b1;
          end
          SUB_FONT: begin
            // First pass forms 5 * Vx; the second adds the glyph base.
            u_a = {6'd0, vx, 2'b00};
            u_b = {8'd0, vx};
            ex_next = S_FONT;
          end
          SUB_BCD: begin ex_next = S_WRD; ex_lim = 4'd2; ex_bcd = 1'b1; end
          SUB_STORE: begin ex_next = S_WRD; ex_lim = fx; end
          SUB_LOAD: ex_status = ST_UNSUP;
          default: ex_status = ST_BAD_OP;
        endcase
      end
    endcase
    ex_ok = (ex_status == ST_OK);
    if (!ex_ok) begin
      ex_next = S_OUT;
      ex_kind = KIND_DONE;
      ex_data = 8'd0;
    end
    // Later states reuse the shared unit for address arithmetic.
    if (state == S_FONT) begin
      u_op = U_ADD;
      u_a  = {4'd0, font_base_q};
      u_b  = tmp_q;
    end else if (state == S_WR) begin
      u_op = U_ADD;
      u_a  = index_q;
      u_b  = {12'd0, cnt};
    end
  end

  assign rf_we    = (state == S_EX && ex_ok && ex_rwe) || (state == S_FLAG);
  assign rf_waddr = (state == S_FLAG) ? 4'hF : fx;
  assign rf_wdata = (state == S_FLAG) ? {7'd0, flag_q} : ex_rdata;

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (cmd.valid) state_next = S_RD;
      S_RD:   state_next = S_EX;
      S_EX:   state_next = ex_next;
      S_FLAG: state_next = S_OUT;
      S_FONT: state_next = S_OUT;
      S_OUT:  if (out_free) state_next = S_IDLE;
      S_WRD:  state_next = S_WR;
      S_WR:   if (out_free) state_next = wr_last ? S_IDLE : S_WRD;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Architectural state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= PC_RESET;
      index_q     <= 16'd0;
      sp          <= '0;
      font_base_q <= FONT_RESET;
    end else begin
      if (cfg.valid) begin
        font_base_q <= cfg.font_base;
      end
      if (state == S_EX && ex_ok) begin
        pc <= ex_pc;
        if (ex_idx_we) index_q <= ex_idx;
        if (ex_push) sp <= sp + {{(SP_W-1){1'b0}}, 1'b1};
        if (ex_pop) sp <= sp_m1;
      end
      if (state == S_FONT) begin
        index_q <= u_y;
      end
    end
  end

  // Return stack storage; the pop address is read while the item is decoded.
  always_ff @(posedge clk) begin
    if (state == S_EX && ex_ok && ex_push) begin
      stk_mem[sp[STK_AW-1:0]] <= pc_adv;
    end
    stk_rdata <= stk_mem[stk_raddr];
  end

  // Item and working registers.
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q   <= cmd.opcode;
      keys_q <= cmd.key_down_mask;
      kv_q   <= cmd.key_event_valid;
      ki_q   <= cmd.key_event_index;
      rnd_q  <= cmd.random_byte;
      dt_q   <= cmd.delay_timer_now;
    end
    if (state == S_EX) begin
      status_q <= ex_status;
      kind_q   <= ex_kind;
      data_q   <= ex_data;
      tmp_q    <= u_y;
      flag_q   <= u_flag;
      vx_q     <= vx;
      cnt      <= 4'd0;
      lim      <= ex_lim;
      bcd_q    <= ex_bcd;
    end else if (state == S_WR && out_free && !wr_last) begin
      cnt <= cnt + 4'd1;
    end
  end

  // Output register: the next item may be accepted while a result waits here.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid_q <= 1'b0;
    end else if ((state == S_OUT || state == S_WR) && out_free) begin
      res_valid_q <= 1'b1;
    end else if (res.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      res_kind_q   <= kind_q;
      res_addr_q   <= 16'd0;
      res_data_q   <= data_q;
      res_pc_q     <= pc;
      res_status_q <= status_q;
      res_last_q   <= 1'b1;
    end else if (state == S_WR && out_free) begin
      res_kind_q   <= KIND_MEMW;
      res_addr_q   <= u_y;
      res_data_q   <= bcd_q ? bcd_digit(vx_q, cnt[1:0]) : vx;
      res_pc_q     <= pc;
      res_status_q <= ST_OK;
      res_last_q   <= wr_last;
    end
  end

  assign res.valid       = res_valid_q;
  assign res.kind        = res_kind_q;
  assign res.mem_address = res_addr_q;
  assign res.data        = res_data_q;
  assign res.next_pc     = res_pc_q;
  assign res.status      = res_status_q;
  assign res.last        = res_last_q;

  // An accepted item keeps the block busy in the following cycle.
  `BVM_ASSERT_NEXT(a_busy_after_accept, cmd.valid && cmd.ready, !cmd.ready)
  // The stack pointer never runs past the stack.
  `BVM_ASSERT_NOW(a_sp_bound, 1'b1, sp <= SP_W'(STACK_DEPTH))
  // An error result is always a single done item.
  `BVM_ASSERT_NOW(a_err_single, res.valid && res.status != ST_OK,
                  res.kind == KIND_DONE && res.last)
  // Store walk never passes its limit.
  `BVM_ASSERT_NOW(a_walk_bound, state == S_WR || state == S_WRD, cnt <= lim)

endmodule
`default_nettype wire

### rtl/core/bvm_unit.sv
// Shared arithmetic unit: add, subtract, logic ops and byte shifts with flag.
`default_nettype none
module bvm_unit
  import bvm_pkg::*;
(
  input  unit_op_t    op,
  input  logic [15:0] a,
  input  logic [15:0] b,
  output logic [15:0] y,
  output logic        flag
);
  logic [16:0] sum;
  logic [16:0] diff;

  assign sum  = {1'b0, a} + {1'b0, b};
  assign diff = {1'b0, a} - {1'b0, b};

  // Flags follow byte semantics: carry out of bit 7, no borrow, shifted-out bit.
  always_comb begin
    unique case (op)
      U_ADD: begin y = sum[15:0]; flag = sum[8]; end
      U_SUB: begin y = diff[15:0]; flag = ~diff[16]; end
      U_OR:  begin y = a | b; flag = 1'b0; end
      U_AND: begin y = a & b; flag = 1'b0; end
      U_XOR: begin y = a ^ b; flag = 1'b0; end
      U_SHR: begin y = {9'd0, a[7:1]}; flag = a[0]; end
      U_SHL: begin y = {8'd0, a[6:0], 1'b0}; flag = a[7]; end
      default: begin y = 16'd0; flag = 1'b0; end
    endcase
  end
endmodule
`default_nettype wire

### rtl/core/bvm_regs.sv
// Sixteen 8-bit general registers, one write port, two registered read ports.
`default_nettype none
module bvm_regs
  import bvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       we,
  input  logic [3:0] waddr,
  input  logic [7:0] wdata,
  input  logic [3:0] raddr_a,
  input  logic [3:0] raddr_b,
  output logic [7:0] rdata_a,
  output logic [7:0] rdata_b
);
  logic [7:0]  mem [16];
  logic [15:0] written;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= written[raddr_a] ? mem[raddr_a] : 8'd0;
    rdata_b <= written[raddr_b] ? mem[raddr_b] : 8'd0;
  end

  // A register never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end
endmodule
`default_nettype wire
